// ===== sv/assert_macros.svh =====
// Assertion macros included by the top level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== sv/tssc_pkg.sv =====
// Types, constants and CRC function for the scratchpad checker
package tssc_pkg;

   localparam int FRAME_BYTES_DEFAULT = 9;
   localparam logic [7:0] MAX_SLOTS_RESET = 8'd8;
   localparam logic [7:0] SLOT_LIMIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h8C;

   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_END_SCAN = 1'b1;

   localparam logic [1:0] ST_VALID = 2'd0;
   localparam logic [1:0] ST_CRC_BAD = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [15:0] temperature;
      logic [7:0]         slot_index;
      logic [7:0]         sensor_count;
   } result_type;

   typedef struct packed {
      logic       overflowed;
      logic [7:0] slot_counter;
   } scan_type;

   function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== sv/temp_sensor_scratchpad_checker.sv =====
// Top level of the temperature sensor scratchpad checker
// Usage:
//   req_ channel: one scratchpad byte per item (req_type 0), or an end of
//   scan marker (req_type 1). Each sensor frame is FRAME_BYTES bytes, the
//   last one being the CRC-8 of the bytes before it.
//   rsp_ channel: at most one item per request: a reading with its slot, a
//   CRC error, a slot overflow, or the scan count at end of scan.
//   csr_ channel: writes max_slots; csr_ready is always high. Write only
//   while the block is idle.
// Path: a request accepted is held in the input register, and its result is
//   loaded into the result register once that register is free to take it.
// Throughput: one request per cycle while no result is stalled, set by the
//   single pass from input register through the CRC xor network to the
//   result register.
// Reset: synchronous; clears the frame state, the scan state and both
//   registers' valid flags, and sets max_slots to 8.
// Stall: while rsp_stall holds a result, the input register keeps its item
//   and req_stall rises; the request channel waits for the result to go.
`include "assert_macros.svh"
module temp_sensor_scratchpad_checker #(
   parameter int FRAME_BYTES = tssc_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic [7:0]         req_data_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [15:0] rsp_temperature,
   output logic [7:0]         rsp_slot_index,
   output logic [7:0]         rsp_sensor_count,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_max_slots
);

   logic                 in_valid_ff;
   tssc_pkg::item_type   in_item_ff;
   logic [7:0]           max_slots_ff;
   logic                 out_free;
   logic                 fire;
   logic                 has_result;
   tssc_pkg::result_type result;
   tssc_pkg::result_type held;
   tssc_pkg::scan_type   scan;
   logic                 in_load;

   assign csr_ready = 1'b1;
   assign fire = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign in_load = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_slots_ff <= tssc_pkg::MAX_SLOTS_RESET;
      end else if (csr_valid && csr_ready) begin
         max_slots_ff <= csr_max_slots;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_item_ff.req_type <= req_type;
         in_item_ff.data_byte <= req_data_byte;
      end
   end

   tssc_frame #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_frame (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .item       (in_item_ff),
      .max_slots  (max_slots_ff),
      .has_result (has_result),
      .result     (result),
      .scan       (scan)
   );

   tssc_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (fire && has_result),
      .result    (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .free      (out_free),
      .held      (held)
   );

   assign rsp_status = held.status;
   assign rsp_temperature = held.temperature;
   assign rsp_slot_index = held.slot_index;
   assign rsp_sensor_count = held.sensor_count;

   `ASSERT_NEXT(a_end_clears, clock, reset, fire && in_item_ff.req_type == tssc_pkg::REQ_END_SCAN, !scan.overflowed && scan.slot_counter == 8'd0, "end of scan did not clear state")
   `ASSERT_IMPLY(a_stall_held, clock, reset, req_stall, in_valid_ff && rsp_valid, "stall without held item")
   `ASSERT_IMPLY(a_count_done, clock, reset, rsp_valid && rsp_status != tssc_pkg::ST_DONE, rsp_sensor_count == 8'd0, "count outside scan done")
   `ASSERT_NEXT(a_ovf_silent, clock, reset, scan.overflowed && fire && in_item_ff.req_type == tssc_pkg::REQ_BYTE, scan.overflowed, "overflow left without end of scan")

endmodule

// ===== sv/tssc_frame.sv =====
// Frame state, CRC check and result selection for one item
module tssc_frame #(
   parameter int FRAME_BYTES = tssc_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  tssc_pkg::item_type   item,
   input  logic [7:0]           max_slots,
   output logic                 has_result,
   output tssc_pkg::result_type result,
   output tssc_pkg::scan_type   scan
);

   localparam int PosW = $clog2(FRAME_BYTES);
   localparam logic [PosW-1:0] LastPos = PosW'(FRAME_BYTES - 1);

   logic [PosW-1:0] pos_ff, pos_in;
   logic [7:0]      crc_ff, crc_in;
   logic [7:0]      lo_ff, lo_in;
   logic [7:0]      hi_ff, hi_in;
   logic [7:0]      slot_ff, slot_in;
   logic            ovf_ff, ovf_in;
   logic [7:0]      slot_inc;
   logic [15:0]     raw;

   assign slot_inc = (slot_ff == tssc_pkg::SLOT_LIMIT) ? slot_ff : slot_ff + 8'd1;
   assign raw = {hi_ff, lo_ff};

   always_comb begin
      pos_in = pos_ff;
      crc_in = crc_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      slot_in = slot_ff;
      ovf_in = ovf_ff;
      has_result = 1'b0;
      result = '0;
      if (item.req_type == tssc_pkg::REQ_END_SCAN) begin
         has_result = 1'b1;
         if (ovf_ff) begin
            result.status = tssc_pkg::ST_OVERFLOW;
         end else begin
            result.status = tssc_pkg::ST_DONE;
            result.sensor_count = slot_ff;
         end
         pos_in = '0;
         crc_in = '0;
         lo_in = '0;
         hi_in = '0;
         slot_in = '0;
         ovf_in = 1'b0;
      end else if (!ovf_ff) begin
         if (pos_ff != LastPos) begin
            if (pos_ff == PosW'(0)) begin
               lo_in = item.data_byte;
            end
            if (pos_ff == PosW'(1)) begin
               hi_in = item.data_byte;
            end
            crc_in = tssc_pkg::crc_update(crc_ff, item.data_byte);
            pos_in = pos_ff + PosW'(1);
         end else begin
            has_result = 1'b1;
            pos_in = '0;
            crc_in = '0;
            result.slot_index = slot_ff;
            if (crc_ff != item.data_byte) begin
               result.status = tssc_pkg::ST_CRC_BAD;
               slot_in = slot_inc;
            end else if (slot_ff < max_slots) begin
               result.status = tssc_pkg::ST_VALID;
               result.temperature = {raw[12:0], 3'b000};
               slot_in = slot_inc;
            end else begin
               result.status = tssc_pkg::ST_OVERFLOW;
               ovf_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         crc_ff <= '0;
         lo_ff <= '0;
         hi_ff <= '0;
         slot_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (fire) begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         slot_ff <= slot_in;
         ovf_ff <= ovf_in;
      end
   end

   assign scan.overflowed = ovf_ff;
   assign scan.slot_counter = slot_ff;

endmodule

// ===== sv/tssc_rsp_reg.sv =====
// Result register on the response channel
module tssc_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  tssc_pkg::result_type result,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic                 free,
   output tssc_pkg::result_type held
);

   logic                 valid_ff;
   tssc_pkg::result_type data_ff;

   assign free = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign held = data_ff;

endmodule
